// ===== rtl/pbs_pkg.sv =====
// Package for the polyphonic beep synthesizer: sequencer states, op codes,
// default parameters, fixed-point constants and the sine polynomial.
// No dependencies.
package pbs_pkg;

  localparam int VOICES_DEF           = 8;
  localparam int FADE_SAMPLES_DEF     = 256;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 24;

  localparam int AMP_W = 15;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd8191;

  // phase step = (freq * 19 << (PHASE_BITS-4) + 441000) / 882000
  localparam int STEP_MUL   = 19;
  localparam int STEP_ROUND = 441000;
  localparam int STEP_DIV   = 882000;
  // 882000 = 16 * 55125: drop 4 low bits, then reciprocal-multiply by 1/55125
  localparam int STEP_PRE_SH = 4;
  localparam int RECIP_SH    = 48;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FRAME  = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EVAL,
    ST_MUL2,
    ST_MUL3,
    ST_WR,
    ST_DONE
  } state_t;

  // Q30 odd polynomial per quarter wave; ux is a 32-bit fraction of a cycle.
  function automatic logic signed [15:0] sine_poly(input logic [63:0] ux);
    logic [1:0]  quad;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] s;
    logic [15:0] v;
    quad = ux[31:30];
    z = {34'd0, ux[29:0]};
    if (quad[0]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    p = 64'd172273;
    p = 64'd5026993 - ((z2 * p) >> 30);
    p = 64'd85569306 - ((z2 * p) >> 30);
    p = 64'd693598669 - ((z2 * p) >> 30);
    p = 64'd1686629713 - ((z2 * p) >> 30);
    s = (z * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    v = s[15:0];
    return quad[1] ? $signed(-v) : $signed(v);
  endfunction

endpackage

// ===== rtl/polyphonic_beep_synthesizer.sv =====
// Polyphonic sine beep generator: voice state memory, sequencer, mixer.
// Depends on pbs_pkg.
//
// One item at a time. Voice state sits in a one-port synchronous memory that
// the sequencer walks one voice at a time (read, modify, write back), so the
// voice loop sets the rate: a sample tick reads and evaluates each idle voice
// and takes each playing voice through read, fade multiply, reciprocal
// multiply and sine read, sine multiply, write/accumulate; a frame tick reads
// and evaluates each voice and writes back each playing one; a start runs a
// reciprocal multiply for the phase step, then a least-time search over all
// voices when no voice is idle, then updates the chosen voice. Unused op
// codes go straight to the result. An input transaction is accepted while
// the previous result still waits in the output register. The memory needs
// no clearing pass: per-voice valid bits make unwritten entries read as zero.
module polyphonic_beep_synthesizer #(
  parameter int VOICES           = pbs_pkg::VOICES_DEF,
  parameter int FADE_SAMPLES     = pbs_pkg::FADE_SAMPLES_DEF,
  parameter int SINE_TABLE_DEPTH = pbs_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = pbs_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // frequency[15:0], length_ms[31:16], elapsed_ms[41:32]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sample[15:0], any_active[16], slot[19:17]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data   // voice_amplitude
);

  localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = $clog2(FADE_SAMPLES + 1);
  localparam int FL    = $clog2(FADE_SAMPLES);
  localparam int XW    = pbs_pkg::AMP_W + CW;
  localparam int KSH   = XW + FL;
  localparam int RCW   = XW + 1;
  localparam logic [RCW-1:0] RECIP =
    RCW'(((64'd1 << KSH) + 64'(FADE_SAMPLES) - 64'd1) / FADE_SAMPLES);
  localparam int IW    = $clog2(SINE_TABLE_DEPTH);
  localparam int AW    = 32 + VIW;

  // phase step = freq * STEP_K + ((freq * STEP_R + round) >> 4) / 55125
  localparam logic [63:0] STEP_C = 64'(pbs_pkg::STEP_MUL) << (PHASE_BITS - 4);
  localparam logic [31:0] STEP_K = 32'(STEP_C / 64'(pbs_pkg::STEP_DIV));
  localparam logic [19:0] STEP_R = 20'(STEP_C % 64'(pbs_pkg::STEP_DIV));
  localparam int RDIV = pbs_pkg::STEP_DIV >> pbs_pkg::STEP_PRE_SH;
  localparam logic [32:0] STEP_M =
    33'(((64'd1 << pbs_pkg::RECIP_SH) + 64'(RDIV) - 64'd1) / 64'(RDIV));

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] step;
    logic signed [16:0]    time_left;
    logic [CW-1:0]         fade_count;
    logic                  fading_in;
    logic                  fading_out;
  } voice_t;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t   r;
    logic [63:0] ux;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ux = (64'(i) << 32) / SINE_TABLE_DEPTH;
      r[i] = pbs_pkg::sine_poly(ux);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  pbs_pkg::state_t state, state_next;

  voice_t mem [VOICES];
  logic [VOICES-1:0] init;
  logic [VOICES-1:0] playing;
  logic [pbs_pkg::AMP_W-1:0] amp;

  logic [1:0]             op_q;
  logic [15:0]            len_q;
  logic [9:0]             elapsed_q;
  logic [VIW-1:0]         vidx;
  logic                   scan;
  logic [31:0]            step_lo;
  logic [31:0]            step_hi;
  logic [64:0]            step_prod;
  logic [PHASE_BITS-1:0]  quot;
  logic [1:0]             div_cnt;
  voice_t                 rd_ent;
  logic                   rd_init;
  voice_t                 new_ent;
  logic [IW-1:0]          idx_q;
  logic [XW-1:0]          prod1;
  logic [XW+RCW-1:0]      prod2;
  logic signed [15:0]     sine_q;
  logic signed [31:0]     prod3;
  logic                   full_q;
  logic                   kill_q;
  logic signed [16:0]     best_tl;
  logic [VIW-1:0]         best_idx;
  logic signed [AW-1:0]   acc;

  logic [15:0] out_sample;
  logic        out_any;
  logic [2:0]  out_slot;

  // combinational helpers
  logic                    last_voice;
  logic                    has_idle;
  logic [VIW-1:0]          first_idle;
  logic [35:0]             step_y;
  voice_t                  ent;
  voice_t                  eval_ent;
  logic [CW-1:0]           cnt_inc;
  logic                    fade_end;
  logic [CW-1:0]           mult;
  logic                    full_c;
  logic                    kill_c;
  logic [PHASE_BITS+IW:0]  idx_prod;
  logic signed [16:0]      tl_n;
  logic                    better;
  logic [pbs_pkg::AMP_W-1:0] a_val;
  logic signed [AW-1:0]    acc_adj;
  logic signed [AW-16:0]   mq;
  logic [15:0]             sat;
  logic                    out_load;

  assign s_tready  = (state == pbs_pkg::ST_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign m_tdata   = {4'd0, out_slot, out_any, out_sample};
  assign last_voice = (vidx == VIW'(VOICES - 1));
  assign out_load  = (state == pbs_pkg::ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    has_idle = 1'b0;
    first_idle = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!playing[i]) begin
        has_idle = 1'b1;
        first_idle = VIW'(i);
      end
    end
  end

  // remainder part of the phase step numerator, below 2^36
  assign step_y = 36'(s_tdata[15:0]) * 36'(STEP_R) + 36'(pbs_pkg::STEP_ROUND);

  // per-voice update
  always_comb begin
    ent = rd_init ? rd_ent : '0;
    eval_ent = ent;
    cnt_inc = ent.fade_count + CW'(1);
    fade_end = (cnt_inc >= CW'(FADE_SAMPLES));
    mult = '0;
    full_c = 1'b1;
    kill_c = 1'b0;
    tl_n = '0;
    idx_prod = (PHASE_BITS+IW+1)'(ent.phase) * (PHASE_BITS+IW+1)'(SINE_TABLE_DEPTH);
    better = (vidx == '0) || ($signed(ent.time_left) < best_tl);
    case (op_q)
      pbs_pkg::OP_SAMPLE: begin
        eval_ent.phase = ent.phase + ent.step;
        if (ent.fading_in) begin
          mult = ent.fade_count;
          full_c = 1'b0;
          eval_ent.fade_count = fade_end ? '0 : cnt_inc;
          eval_ent.fading_in = !fade_end;
        end else if (ent.fading_out) begin
          mult = CW'(FADE_SAMPLES) - ent.fade_count;
          full_c = 1'b0;
          eval_ent.fade_count = cnt_inc;
          kill_c = fade_end;
        end
      end
      pbs_pkg::OP_FRAME: begin
        if ($signed(ent.time_left) < 0) tl_n = '0;
        else if ($signed(ent.time_left) > 0)
          tl_n = $signed(ent.time_left) - $signed({7'd0, elapsed_q});
        else tl_n = '0;
        eval_ent.time_left = tl_n;
        if (tl_n == '0) begin
          eval_ent.fading_out = 1'b1;
          eval_ent.fading_in = 1'b0;
        end
      end
      pbs_pkg::OP_START: begin
        eval_ent.time_left = $signed({1'b0, len_q});
        eval_ent.step = quot;
        eval_ent.fade_count = '0;
        eval_ent.fading_out = 1'b0;
        eval_ent.fading_in = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (kill_q) a_val = '0;
    else if (full_q) a_val = amp;
    else a_val = prod2[KSH +: pbs_pkg::AMP_W];
  end

  // divide by 32768 toward zero, then saturate
  always_comb begin
    acc_adj = (acc < 0) ? acc + AW'(32767) : acc;
    mq = acc_adj[AW-1:15];
    if (mq > $signed((AW-15)'(32767))) sat = 16'h7FFF;
    else if (mq < $signed(-(AW-15)'(32768))) sat = 16'h8000;
    else sat = mq[15:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      pbs_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            pbs_pkg::OP_SAMPLE: state_next = pbs_pkg::ST_RD;
            pbs_pkg::OP_FRAME:  state_next = pbs_pkg::ST_RD;
            pbs_pkg::OP_START:  state_next = pbs_pkg::ST_DIV;
            default:            state_next = pbs_pkg::ST_DONE;
          endcase
        end
      end
      pbs_pkg::ST_DIV: if (div_cnt == 2'd1) state_next = pbs_pkg::ST_RD;
      pbs_pkg::ST_RD: state_next = pbs_pkg::ST_EVAL;
      pbs_pkg::ST_EVAL: begin
        case (op_q)
          pbs_pkg::OP_SAMPLE: begin
            if (playing[vidx]) state_next = pbs_pkg::ST_MUL2;
            else state_next = last_voice ? pbs_pkg::ST_DONE : pbs_pkg::ST_RD;
          end
          pbs_pkg::OP_FRAME: begin
            if (playing[vidx]) state_next = pbs_pkg::ST_WR;
            else state_next = last_voice ? pbs_pkg::ST_DONE : pbs_pkg::ST_RD;
          end
          default: state_next = scan ? pbs_pkg::ST_RD : pbs_pkg::ST_WR;
        endcase
      end
      pbs_pkg::ST_MUL2: state_next = pbs_pkg::ST_MUL3;
      pbs_pkg::ST_MUL3: state_next = pbs_pkg::ST_WR;
      pbs_pkg::ST_WR: begin
        if (op_q == pbs_pkg::OP_START || last_voice) state_next = pbs_pkg::ST_DONE;
        else state_next = pbs_pkg::ST_RD;
      end
      pbs_pkg::ST_DONE: if (!m_tvalid || m_tready) state_next = pbs_pkg::ST_IDLE;
      default: state_next = pbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pbs_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) amp <= pbs_pkg::AMP_RESET;
    else if (cfg_valid) amp <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (state == pbs_pkg::ST_RD) begin
      rd_ent <= mem[vidx];
      rd_init <= init[vidx];
    end
    if (state == pbs_pkg::ST_WR) mem[vidx] <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init <= '0;
      playing <= '0;
    end else if (state == pbs_pkg::ST_WR) begin
      init[vidx] <= 1'b1;
      if (op_q == pbs_pkg::OP_START) playing[vidx] <= 1'b1;
      else if (op_q == pbs_pkg::OP_SAMPLE && kill_q) playing[vidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= 1'b0;
    end else begin
      case (state)
        pbs_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            op_q <= s_tuser;
            len_q <= s_tdata[31:16];
            elapsed_q <= s_tdata[41:32];
            step_lo <= step_y[pbs_pkg::STEP_PRE_SH +: 32];
            step_hi <= 32'(s_tdata[15:0]) * STEP_K;
            quot <= '0;
            div_cnt <= 2'd2;
            vidx <= '0;
            acc <= '0;
            scan <= 1'b0;
          end
        end
        pbs_pkg::ST_DIV: begin
          div_cnt <= div_cnt - 2'd1;
          if (div_cnt == 2'd2) begin
            step_prod <= 65'(step_lo) * 65'(STEP_M);
          end else begin
            quot <= PHASE_BITS'(step_hi + 32'(step_prod[pbs_pkg::RECIP_SH +: 17]));
            // no idle voice: search for the least time left first
            scan <= !has_idle;
            vidx <= has_idle ? first_idle : '0;
          end
        end
        pbs_pkg::ST_EVAL: begin
          new_ent <= eval_ent;
          idx_q <= idx_prod[PHASE_BITS +: IW];
          prod1 <= XW'(amp) * XW'(mult);
          full_q <= full_c;
          kill_q <= kill_c;
          if (scan) begin
            if (better) begin
              best_tl <= $signed(ent.time_left);
              best_idx <= vidx;
            end
            if (last_voice) begin
              scan <= 1'b0;
              vidx <= better ? vidx : best_idx;
            end else begin
              vidx <= vidx + VIW'(1);
            end
          end else if (op_q != pbs_pkg::OP_START && !playing[vidx]) begin
            vidx <= vidx + VIW'(1);
          end
        end
        pbs_pkg::ST_MUL2: begin
          prod2 <= (XW+RCW)'(prod1) * (XW+RCW)'(RECIP);
          sine_q <= SINE_ROM[idx_q];
        end
        pbs_pkg::ST_MUL3: prod3 <= $signed({1'b0, a_val}) * sine_q;
        pbs_pkg::ST_WR: begin
          if (op_q == pbs_pkg::OP_SAMPLE) acc <= acc + AW'(prod3);
          if (op_q != pbs_pkg::OP_START) vidx <= vidx + VIW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= (op_q == pbs_pkg::OP_SAMPLE) ? sat : 16'd0;
      out_any <= |playing;
      out_slot <= (op_q == pbs_pkg::OP_START) ? 3'(vidx) : 3'd0;
    end
  end

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("finished result not presented");

  a_start_plays: assert property (@(posedge clk) disable iff (rst)
    (state == pbs_pkg::ST_WR && op_q == pbs_pkg::OP_START) |=> playing[$past(vidx)])
    else $error("started voice not marked playing");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> acc == '0)
    else $error("mix accumulator not cleared on accept");

  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    scan |-> op_q == pbs_pkg::OP_START)
    else $error("least-time search outside a start");

endmodule
